// File: src/balt_pkg.sv
`default_nettype none
package balt_pkg;

  localparam int HEAP_BYTES  = 4096;
  localparam int TRACK_DEPTH = 64;
  localparam int IDX_W       = $clog2(TRACK_DEPTH);
  localparam int CNT_W       = 7;
  localparam int LEVEL_W     = 13;
  localparam int SIZE_W      = 16;
  localparam int SITE_W      = 16;
  localparam int SUM_W       = 18;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_LIST  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    RC_ALLOC_TRACKED   = 4'd0,
    RC_ALLOC_UNTRACKED = 4'd1,
    RC_NO_SPACE        = 4'd2,
    RC_FREE_MATCH      = 4'd3,
    RC_FREE_UNTRACKED  = 4'd4,
    RC_NULL_FREE       = 4'd5,
    RC_CLEARED         = 4'd6,
    RC_LEAK            = 4'd7,
    RC_NO_LEAKS        = 4'd8
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FREE_CHK,
    ST_FREE_LAST,
    ST_FREE_WR,
    ST_EMIT,
    ST_LIST_OUT
  } state_t;

  typedef struct packed {
    logic [SITE_W-1:0]  site;
    logic [SIZE_W-1:0]  size;
    logic [LEVEL_W-1:0] offset;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage
`default_nettype wire

// File: src/bump_allocator_leak_tracker_top.sv
// Channel | Dir | Handshake          | Payload
// s       | in  | s_tvalid/s_tready  | s_tuser req_type, s_tdata request fields
// m       | out | m_tvalid/m_tready  | m_tuser result_code, m_tdata result, m_tlast
//
// Allocate runs ST_ALLOC, then ST_EMIT, which loads the output register.
// Free scans the table one record per cycle through the table RAM read port;
// on a match, the last record is read and then written into the hole.
// List emits one record per cycle while m_tready stays high.
// rst clears counters, levels and record count; the table RAM keeps its contents.
// A stalled output holds the sequencer only where it must load the output register.
`default_nettype none
module bump_allocator_leak_tracker_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // request_size[15:0], site_tag[31:16], block_address[44:32], pointer_null[45]
  input  wire logic [47:0]  s_tdata,
  // req_type[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // block_offset[12:0], record_size[28:13], record_site[44:29], live_records[51:45],
  // heap_level[64:52], heap_high_mark[77:65], alloc_total[109:78], free_total[141:110]
  output logic      [143:0] m_tdata,
  // result_code[3:0]
  output logic      [3:0]   m_tuser,
  output logic              m_tlast
);

  balt_pkg::state_t  state, state_next;

  logic [balt_pkg::CNT_W-1:0]   record_count;
  logic [balt_pkg::LEVEL_W-1:0] used_level;
  logic [balt_pkg::LEVEL_W-1:0] peak_level;
  logic [31:0]                  alloc_counter;
  logic [31:0]                  free_counter;

  // latched request
  logic [balt_pkg::SIZE_W-1:0]  req_size;
  logic [balt_pkg::SITE_W-1:0]  req_site;
  logic [balt_pkg::LEVEL_W-1:0] req_addr;

  logic [balt_pkg::IDX_W-1:0]   idx;
  balt_pkg::result_t            code;
  logic [balt_pkg::LEVEL_W-1:0] res_off;

  // output register
  balt_pkg::result_t            out_code;
  logic [balt_pkg::LEVEL_W-1:0] out_off;
  logic [balt_pkg::SIZE_W-1:0]  out_size;
  logic [balt_pkg::SITE_W-1:0]  out_site;
  logic [balt_pkg::CNT_W-1:0]   out_count;
  logic [balt_pkg::LEVEL_W-1:0] out_level;
  logic [balt_pkg::LEVEL_W-1:0] out_peak;
  logic [31:0]                  out_alloc;
  logic [31:0]                  out_free_cnt;

  logic                         wr_en;
  logic [balt_pkg::IDX_W-1:0]   wr_addr;
  balt_pkg::rec_t               wr_rec;
  logic [balt_pkg::IDX_W-1:0]   rd_addr;
  logic [balt_pkg::REC_W-1:0]   rd_data;
  balt_pkg::rec_t               rd_rec;

  logic                         accept;
  logic                         out_free;
  logic                         load_out;
  logic [balt_pkg::SUM_W-1:0]   aligned;
  logic [balt_pkg::SUM_W-1:0]   level_sum;
  logic                         fits;
  logic                         has_room;
  logic                         match;
  logic                         at_last;
  balt_pkg::req_t               in_req;

  balt_ram #(
    .WIDTH (balt_pkg::REC_W),
    .DEPTH (balt_pkg::TRACK_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_rec),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_rec   = balt_pkg::rec_t'(rd_data);
  assign in_req   = balt_pkg::req_t'(s_tuser);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign load_out = out_free && (state inside {balt_pkg::ST_EMIT, balt_pkg::ST_LIST_OUT});

  // shared datapath: level adder and compares
  assign aligned   = (balt_pkg::SUM_W'(req_size) + balt_pkg::SUM_W'(3))
                     & ~balt_pkg::SUM_W'(3);
  assign level_sum = balt_pkg::SUM_W'(used_level) + aligned;
  assign fits      = level_sum <= balt_pkg::SUM_W'(balt_pkg::HEAP_BYTES);
  assign has_room  = record_count < balt_pkg::CNT_W'(balt_pkg::TRACK_DEPTH);
  assign match     = rd_rec.offset == req_addr;
  assign at_last   = (balt_pkg::CNT_W'(idx) + balt_pkg::CNT_W'(1)) == record_count;

  always_comb begin
    state_next = state;
    case (state)
      balt_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_req)
            balt_pkg::REQ_ALLOC: state_next = balt_pkg::ST_ALLOC;
            balt_pkg::REQ_FREE: begin
              if (s_tdata[45] || record_count == '0) begin
                state_next = balt_pkg::ST_EMIT;
              end else begin
                state_next = balt_pkg::ST_FREE_CHK;
              end
            end
            balt_pkg::REQ_CLEAR: state_next = balt_pkg::ST_EMIT;
            balt_pkg::REQ_LIST: begin
              if (record_count == '0) begin
                state_next = balt_pkg::ST_EMIT;
              end else begin
                state_next = balt_pkg::ST_LIST_OUT;
              end
            end
            default: state_next = balt_pkg::ST_IDLE;
          endcase
        end
      end
      balt_pkg::ST_ALLOC: state_next = balt_pkg::ST_EMIT;
      balt_pkg::ST_FREE_CHK: begin
        if (match) begin
          state_next = balt_pkg::ST_FREE_LAST;
        end else if (at_last) begin
          state_next = balt_pkg::ST_EMIT;
        end
      end
      balt_pkg::ST_FREE_LAST: state_next = balt_pkg::ST_FREE_WR;
      balt_pkg::ST_FREE_WR: state_next = balt_pkg::ST_EMIT;
      balt_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = balt_pkg::ST_IDLE;
        end
      end
      balt_pkg::ST_LIST_OUT: begin
        if (out_free && at_last) begin
          state_next = balt_pkg::ST_IDLE;
        end
      end
      default: state_next = balt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = idx;
    wr_rec   = rd_rec;
    rd_addr  = '0;
    case (state)
      balt_pkg::ST_IDLE: s_tready = 1'b1;
      balt_pkg::ST_ALLOC: begin
        wr_en       = fits && has_room;
        wr_addr     = record_count[balt_pkg::IDX_W-1:0];
        wr_rec.site = req_site;
        wr_rec.size = req_size;
        wr_rec.offset = used_level;
      end
      // prefetch the next record while comparing this one
      balt_pkg::ST_FREE_CHK: rd_addr = idx + balt_pkg::IDX_W'(1);
      balt_pkg::ST_FREE_LAST: begin
        rd_addr = balt_pkg::IDX_W'(record_count - balt_pkg::CNT_W'(1));
      end
      balt_pkg::ST_FREE_WR: wr_en = 1'b1;
      balt_pkg::ST_LIST_OUT: rd_addr = out_free ? idx + balt_pkg::IDX_W'(1) : idx;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= balt_pkg::ST_IDLE;
      record_count  <= '0;
      used_level    <= '0;
      peak_level    <= '0;
      alloc_counter <= '0;
      free_counter  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        balt_pkg::ST_IDLE: begin
          if (accept) begin
            req_size <= s_tdata[15:0];
            req_site <= s_tdata[31:16];
            req_addr <= s_tdata[44:32];
            idx      <= '0;
            res_off  <= '0;
            case (in_req)
              balt_pkg::REQ_FREE: begin
                if (s_tdata[45]) begin
                  code <= balt_pkg::RC_NULL_FREE;
                end else if (record_count == '0) begin
                  code         <= balt_pkg::RC_FREE_UNTRACKED;
                  free_counter <= free_counter + 32'd1;
                end
              end
              balt_pkg::REQ_CLEAR: begin
                record_count  <= '0;
                used_level    <= '0;
                peak_level    <= '0;
                alloc_counter <= '0;
                free_counter  <= '0;
                code          <= balt_pkg::RC_CLEARED;
              end
              balt_pkg::REQ_LIST: code <= balt_pkg::RC_NO_LEAKS;
              default: code <= balt_pkg::RC_NO_SPACE;
            endcase
          end
        end
        balt_pkg::ST_ALLOC: begin
          if (!fits) begin
            code <= balt_pkg::RC_NO_SPACE;
          end else begin
            res_off       <= used_level;
            used_level    <= level_sum[balt_pkg::LEVEL_W-1:0];
            alloc_counter <= alloc_counter + 32'd1;
            if (level_sum[balt_pkg::LEVEL_W-1:0] > peak_level) begin
              peak_level <= level_sum[balt_pkg::LEVEL_W-1:0];
            end
            if (has_room) begin
              record_count <= record_count + balt_pkg::CNT_W'(1);
              code         <= balt_pkg::RC_ALLOC_TRACKED;
            end else begin
              code <= balt_pkg::RC_ALLOC_UNTRACKED;
            end
          end
        end
        balt_pkg::ST_FREE_CHK: begin
          if (!match) begin
            if (at_last) begin
              code         <= balt_pkg::RC_FREE_UNTRACKED;
              free_counter <= free_counter + 32'd1;
            end else begin
              idx <= idx + balt_pkg::IDX_W'(1);
            end
          end
        end
        balt_pkg::ST_FREE_WR: begin
          record_count <= record_count - balt_pkg::CNT_W'(1);
          free_counter <= free_counter + 32'd1;
          code         <= balt_pkg::RC_FREE_MATCH;
        end
        balt_pkg::ST_EMIT: begin
          if (out_free) begin
            m_tlast      <= 1'b1;
            out_code     <= code;
            out_off      <= res_off;
            out_size     <= '0;
            out_site     <= '0;
            out_count    <= record_count;
            out_level    <= used_level;
            out_peak     <= peak_level;
            out_alloc    <= alloc_counter;
            out_free_cnt <= free_counter;
          end
        end
        balt_pkg::ST_LIST_OUT: begin
          if (out_free) begin
            m_tlast      <= at_last;
            out_code     <= balt_pkg::RC_LEAK;
            out_off      <= rd_rec.offset;
            out_size     <= rd_rec.size;
            out_site     <= rd_rec.site;
            out_count    <= record_count;
            out_level    <= used_level;
            out_peak     <= peak_level;
            out_alloc    <= alloc_counter;
            out_free_cnt <= free_counter;
            idx          <= idx + balt_pkg::IDX_W'(1);
          end
        end
        default: idx <= idx;
      endcase
    end
  end

  assign m_tuser = out_code;
  assign m_tdata = {2'b00, out_free_cnt, out_alloc, out_peak, out_level, out_count,
                    out_site, out_size, out_off};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    record_count <= balt_pkg::CNT_W'(balt_pkg::TRACK_DEPTH))
    else $error("record count beyond table depth");

  a_peak_covers_level: assert property (@(posedge clk) disable iff (rst)
    peak_level >= used_level)
    else $error("peak level below used level");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    used_level <= balt_pkg::LEVEL_W'(balt_pkg::HEAP_BYTES))
    else $error("used level beyond heap");

  a_free_drops_one: assert property (@(posedge clk) disable iff (rst)
    state == balt_pkg::ST_FREE_WR |=>
      record_count == balt_pkg::CNT_W'($past(record_count) - balt_pkg::CNT_W'(1)))
    else $error("matched free did not remove exactly one record");

endmodule
`default_nettype wire

// File: src/balt_ram.sv
`default_nettype none
module balt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
